// ----- design/assert_macros.svh -----
// Assertion macros shared by the segment table allocator RTL.
// Clocked on clock; the first form is masked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high
`define STA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define STA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- design/stalloc_pkg.sv -----
// Shared types and constants for the segment table allocator.
// No dependencies; imported by stalloc_cell and segment_table_allocator_core.
package stalloc_pkg;

   localparam int SEGMENTS      = 16;
   localparam int ADDR_BITS     = 24;
   localparam int END_BITS      = ADDR_BITS + 1;
   localparam int PHYS_BITS     = 25;
   localparam int COUNT_BITS    = $clog2(SEGMENTS + 1);
   localparam int END_OFFSET    = 1;
   localparam int RESERVED_BASE = 0;

   localparam logic [PHYS_BITS-1:0] MEM_AVAIL_RESET = PHYS_BITS'(16384);

   // request commands
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_ACCESS = 2'd1;
   localparam logic [1:0] CMD_NEW    = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   // response status
   localparam logic [1:0] STAT_GRANT  = 2'd0;
   localparam logic [1:0] STAT_FAULT  = 2'd1;
   localparam logic [1:0] STAT_IGNORE = 2'd2;

   typedef struct packed {
      logic [ADDR_BITS-1:0] vstart;
      logic [END_BITS-1:0]  vend;
   } seg_type;

   typedef struct packed {
      logic collide;
      logic hit;
   } cell_flags_type;

endpackage

// ----- design/segment_table_allocator_core.sv -----
// Segment table allocator top level: request capture, chain of segment
// cells, decision logic and response register. Depends on stalloc_pkg,
// stalloc_cell and assert_macros.svh.
//
//   channel   ports                              direction
//   req       req_valid/ready, cmd, vaddr, len   in
//   rsp       rsp_valid/ready, status, base      out
//   csr       csr_wr_en, csr_wr_data             in (mem_available)
//
// A request passes the compare state for the per-cell compares (all cells in
// parallel, flags registered), then the decision state, which merges flags and updates the table.
// The next request is taken in the decision cycle, so a new request can be
// accepted while the last one is being decided. Reset (synchronous) empties the table and
// clears the fault; a stalled response holds the decision cycle.
`include "assert_macros.svh"

module segment_table_allocator_core
   import stalloc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [ADDR_BITS-1:0]  req_vaddr,
   input  logic [ADDR_BITS-1:0]  req_span_length,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [PHYS_BITS-1:0]  rsp_phys_base,
   input  logic                  csr_wr_en,
   input  logic [PHYS_BITS-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_DEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]            cmd_ff;
   logic [ADDR_BITS-1:0]  vaddr_ff;
   logic [ADDR_BITS-1:0]  len_ff;
   logic [END_BITS-1:0]   top;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PHYS_BITS-1:0]  used_end_ff, used_end_in;
   logic                  faulted_ff, faulted_in;
   logic [PHYS_BITS-1:0]  mem_avail_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [PHYS_BITS-1:0]  rsp_phys_base_ff;

   seg_type               new_seg;
   seg_type               chain [SEGMENTS+1];
   cell_flags_type        flags [SEGMENTS];
   logic [SEGMENTS-1:0]   in_use;
   logic [SEGMENTS-1:0]   coll_vec;
   logic [SEGMENTS-1:0]   hit_vec;

   logic                  can_emit;
   logic                  dec_fire;
   logic                  accept;
   logic                  grant;
   logic                  res_coll;
   logic [PHYS_BITS:0]    need;
   logic                  alloc_ok;
   logic [1:0]            status_in;
   logic [PHYS_BITS-1:0]  base_in;

   assign top = {1'b0, vaddr_ff} + {1'b0, len_ff};

   // new segment enters at cell 0; older ones move one cell down
   always_comb begin
      new_seg.vstart = vaddr_ff;
      new_seg.vend   = END_BITS'(top - END_BITS'(END_OFFSET));
   end
   assign chain[0] = new_seg;

   for (genvar i = 0; i < SEGMENTS; i++) begin : g_cell
      stalloc_cell u_cell (
         .clock     (clock),
         .shift_en  (grant),
         .seg_in    (chain[i]),
         .req_vaddr (vaddr_ff),
         .req_top   (top),
         .seg_out   (chain[i+1]),
         .flags_out (flags[i])
      );
      assign in_use[i]   = COUNT_BITS'(i) < count_ff;
      assign coll_vec[i] = flags[i].collide & in_use[i];
      assign hit_vec[i]  = flags[i].hit & in_use[i];
   end

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign dec_fire  = (state_ff == ST_DEC) && can_emit;
   assign req_ready = (state_ff == ST_IDLE) || dec_fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      res_coll = (vaddr_ff == ADDR_BITS'(RESERVED_BASE))
              || (top == END_BITS'(RESERVED_BASE))
              || ((vaddr_ff <= ADDR_BITS'(RESERVED_BASE))
                  && (top >= END_BITS'(RESERVED_BASE)));
      need     = {1'b0, used_end_ff} + (PHYS_BITS + 1)'(len_ff);
      alloc_ok = !res_coll && !(|coll_vec)
              && (need <= {1'b0, mem_avail_ff})
              && (count_ff < COUNT_BITS'(SEGMENTS));

      grant       = 1'b0;
      count_in    = count_ff;
      used_end_in = used_end_ff;
      faulted_in  = faulted_ff;
      status_in   = STAT_GRANT;
      base_in     = '0;

      if (dec_fire) begin
         priority if (cmd_ff == CMD_NEW) begin
            count_in    = '0;
            used_end_in = '0;
            faulted_in  = 1'b0;
         end else if ((cmd_ff == CMD_RSVD) || faulted_ff) begin
            status_in = STAT_IGNORE;
         end else if (cmd_ff == CMD_ALLOC) begin
            if (alloc_ok) begin
               grant       = 1'b1;
               count_in    = count_ff + COUNT_BITS'(1);
               base_in     = used_end_ff;
               used_end_in = need[PHYS_BITS-1:0];
            end else begin
               faulted_in = 1'b1;
               status_in  = STAT_FAULT;
            end
         end else begin
            if (!(|hit_vec)) begin
               faulted_in = 1'b1;
               status_in  = STAT_FAULT;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CMP;
         ST_CMP:  state_in = ST_DEC;
         ST_DEC: begin
            if (dec_fire) state_in = accept ? ST_CMP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_end_ff  <= '0;
         faulted_ff   <= 1'b0;
         mem_avail_ff <= MEM_AVAIL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         used_end_ff <= used_end_in;
         faulted_ff  <= faulted_in;
         if (csr_wr_en) begin
            mem_avail_ff <= csr_wr_data;
         end
         if (dec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         vaddr_ff <= req_vaddr;
         len_ff   <= req_span_length;
      end
      if (dec_fire) begin
         rsp_status_ff    <= status_in;
         rsp_phys_base_ff <= base_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_phys_base = rsp_phys_base_ff;

   `STA_ASSERT(a_count_bound, count_ff <= COUNT_BITS'(SEGMENTS), "segment count overflow")
   `STA_ASSERT(a_no_accept_in_cmp, (state_ff == ST_CMP) |-> !req_ready, "request taken mid compare")
   `STA_ASSERT(a_rsp_after_dec, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DEC), "response without decision")
   `STA_ASSERT(a_base_only_grant, (rsp_valid_ff && (rsp_phys_base_ff != '0)) |-> (rsp_status_ff == STAT_GRANT), "base on non-grant")
   `STA_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (state_ff == ST_IDLE) && !rsp_valid_ff, "not idle after reset")

endmodule

// ----- design/stalloc_cell.sv -----
// One segment cell: holds a segment, passes it to the next cell on append,
// and registers its collision / containment flags. Depends on stalloc_pkg.
module stalloc_cell
   import stalloc_pkg::*;
(
   input  logic                 clock,
   input  logic                 shift_en,
   input  seg_type              seg_in,
   input  logic [ADDR_BITS-1:0] req_vaddr,
   input  logic [END_BITS-1:0]  req_top,
   output seg_type              seg_out,
   output cell_flags_type       flags_out
);

   seg_type        seg_ff;
   cell_flags_type flags_ff;
   cell_flags_type flags_in;

   logic [END_BITS-1:0] v_ext;
   logic [END_BITS-1:0] s_ext;
   logic [END_BITS:0]   lim;
   logic                v_inside;

   always_comb begin
      v_ext    = {1'b0, req_vaddr};
      s_ext    = {1'b0, seg_ff.vstart};
      lim      = {1'b0, seg_ff.vend} + (END_BITS + 1)'(END_OFFSET);
      v_inside = (v_ext >= s_ext) && (v_ext <= seg_ff.vend);
      flags_in.collide = v_inside
                       || ((req_top >= s_ext) && (req_top <= seg_ff.vend))
                       || ((v_ext <= s_ext) && (req_top >= s_ext));
      flags_in.hit     = v_inside && ({1'b0, req_top} <= lim);
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         seg_ff <= seg_in;
      end
      flags_ff <= flags_in;
   end

   assign seg_out   = seg_ff;
   assign flags_out = flags_ff;

endmodule

// ----- verif/segment_table_allocator_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for segment_table_allocator_core: scoreboard class,
// request/response drivers and a random process generator. Needs stalloc_pkg.
module segment_table_allocator_core_test
   import stalloc_pkg::*;
();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int REGION_STRIDE = 'hF0000;
   localparam int LAST_REGION   = 17;

   typedef struct {
      logic [1:0]           status;
      logic [PHYS_BITS-1:0] base;
   } rsp_entry_type;

   // Tracks the segment table of the current process and the responses owed.
   class segment_ledger_type;
      logic [ADDR_BITS-1:0] seg_lo[SEGMENTS];
      logic [END_BITS-1:0]  seg_hi[SEGMENTS];
      int                   seg_count;
      logic [PHYS_BITS-1:0] used_end;
      logic [PHYS_BITS-1:0] mem_avail;
      bit                   faulted;
      rsp_entry_type        owed_rsp[$];
      int errors, alloc_grants, access_grants, faults, full_faults, ignored;

      function new();
         seg_count = 0;
         used_end  = '0;
         faulted   = 1'b0;
         mem_avail = MEM_AVAIL_RESET;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function bit overlaps(longint unsigned v, longint unsigned top,
                            longint unsigned s, longint unsigned e);
         return (v >= s && v <= e) || (top >= s && top <= e) || (v <= s && top >= s);
      endfunction

      // Apply one accepted request to the table and queue its response.
      function logic [1:0] note_request(logic [1:0] cmd, logic [ADDR_BITS-1:0] vaddr,
                                        logic [ADDR_BITS-1:0] span);
         longint unsigned v, len, top, need;
         bit ok;
         rsp_entry_type r;
         v = 64'(vaddr);
         len = 64'(span);
         top = v + len;
         r.status = STAT_GRANT;
         r.base = '0;
         if (cmd == CMD_NEW) begin
            seg_count = 0;
            used_end  = '0;
            faulted   = 1'b0;
         end else if (cmd == CMD_RSVD || faulted) begin
            r.status = STAT_IGNORE;
            ignored++;
         end else if (cmd == CMD_ALLOC) begin
            ok = !overlaps(v, top, RESERVED_BASE, RESERVED_BASE);
            for (int i = 0; i < seg_count; i++)
               if (overlaps(v, top, seg_lo[i], seg_hi[i]))
                  ok = 1'b0;
            need = 64'(used_end);
            need += len;
            if (need > mem_avail)
               ok = 1'b0;
            if (seg_count >= SEGMENTS)
               ok = 1'b0;
            if (ok) begin
               seg_lo[seg_count] = vaddr;
               seg_hi[seg_count] = END_BITS'(top - END_OFFSET);
               seg_count++;
               r.base   = used_end;
               used_end = PHYS_BITS'(need);
               alloc_grants++;
            end else begin
               if (seg_count >= SEGMENTS)
                  full_faults++;
               faulted  = 1'b1;
               r.status = STAT_FAULT;
               faults++;
            end
         end else begin
            ok = 1'b0;
            for (int i = 0; i < seg_count; i++)
               if (v >= seg_lo[i] && v <= seg_hi[i] && top <= seg_hi[i] + END_OFFSET)
                  ok = 1'b1;
            if (ok) begin
               access_grants++;
            end else begin
               faulted  = 1'b1;
               r.status = STAT_FAULT;
               faults++;
            end
         end
         owed_rsp.push_back(r);
         return r.status;
      endfunction

      function void check_result(logic [1:0] status, logic [PHYS_BITS-1:0] base);
         rsp_entry_type want;
         if (owed_rsp.size() == 0) begin
            flag($sformatf("response with none outstanding: status %0d base 0x%0h",
                           status, base));
            return;
         end
         want = owed_rsp.pop_front();
         if (status !== want.status)
            flag($sformatf("status: expected %0d, got %0d", want.status, status));
         if (base !== want.base)
            flag($sformatf("phys_base: expected 0x%0h, got 0x%0h", want.base, base));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_cmd;
   logic [ADDR_BITS-1:0] req_vaddr;
   logic [ADDR_BITS-1:0] req_span_length;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [PHYS_BITS-1:0] rsp_phys_base;
   logic                 csr_wr_en;
   logic [PHYS_BITS-1:0] csr_wr_data;

   segment_ledger_type sb;
   int burst_left = 0;
   int work_sent  = 0;
   int mem_sizes  = 1;
   int cycles     = 0;
   int rx_mode    = 0;
   int rx_left    = 0;
   int rx_hold    = 0;
   int rx_phase   = 0;

   segment_table_allocator_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_vaddr       (req_vaddr),
      .req_span_length (req_span_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_phys_base   (rsp_phys_base),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, sb.owed_rsp.size());
         $display("segment_table_allocator_core_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_phys_base);
   end

   // Receiver back-pressure: switch at random between steady, random, long-stall
   // and one-in-three patterns.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(40, 160);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         2: begin
            if (rx_hold == 0) begin
               rsp_ready = !rsp_ready;
               rx_hold = rsp_ready ? $urandom_range(1, 4) : $urandom_range(1, 12);
            end
            rx_hold--;
         end
         default: rsp_ready = (rx_phase % 3 == 0);
      endcase
   end

   // Present one request, hold it until accepted; returns at a falling edge.
   task automatic send_request(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] vaddr,
                               input logic [ADDR_BITS-1:0] span);
      logic [1:0] predicted;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
      end
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_vaddr       = vaddr;
      req_span_length = span;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = sb.note_request(cmd, vaddr, span);
      if (predicted != STAT_IGNORE)
         work_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every response is back.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.owed_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mem_avail(input logic [PHYS_BITS-1:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      sb.mem_avail = value;
      mem_sizes++;
   endtask

   // One process: new, then allocations in separate regions mixed with
   // accesses, some colliding or overrunning requests and a little noise.
   task automatic run_process(input int goal);
      int region, n_ops, pick, idx;
      longint unsigned lo, hi, v, len;
      send_request(CMD_NEW, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
      region = 1;
      n_ops = $urandom_range(2, 40);
      for (int i = 0; i < n_ops && work_sent < goal; i++) begin
         if (sb.faulted) begin
            repeat ($urandom_range(0, 2))
               send_request($urandom_range(0, 1) ? CMD_ALLOC : CMD_ACCESS,
                            ADDR_BITS'($urandom), ADDR_BITS'($urandom));
            break;
         end
         pick = $urandom_range(0, 99);
         if ((pick < 45 || sb.seg_count == 0) && region <= LAST_REGION) begin
            v = region * REGION_STRIDE + $urandom_range(0, 'hFFF);
            case ($urandom_range(0, 7))
               0:       len = 0;
               1, 2:    len = $urandom_range('h1000, 'hE0000);
               default: len = $urandom_range(1, 'hFFF);
            endcase
            region++;
            send_request(CMD_ALLOC, ADDR_BITS'(v), ADDR_BITS'(len));
         end else if (pick < 85 && sb.seg_count != 0) begin
            idx = $urandom_range(0, sb.seg_count - 1);
            lo = 64'(sb.seg_lo[idx]);
            hi = 64'(sb.seg_hi[idx]);
            if (hi < lo) begin
               v = lo;
               len = 0;
            end else begin
               v = lo + $urandom_range(0, hi - lo);
               len = $urandom_range(0, hi + 1 - v);
               if ($urandom_range(0, 7) == 0)
                  len++;
            end
            send_request(CMD_ACCESS, ADDR_BITS'(v), ADDR_BITS'(len));
         end else if (pick < 94 && sb.seg_count != 0) begin
            idx = $urandom_range(0, sb.seg_count - 1);
            lo = 64'(sb.seg_lo[idx]);
            if ($urandom_range(0, 1)) begin
               len = $urandom_range(1, 64);
               v = lo - len;
            end else begin
               v = lo + $urandom_range(0, 4);
               len = $urandom_range(0, 256);
            end
            send_request(CMD_ALLOC, ADDR_BITS'(v), ADDR_BITS'(len));
         end else begin
            send_request($urandom_range(0, 1) ? CMD_ACCESS : CMD_RSVD,
                         ADDR_BITS'($urandom), ADDR_BITS'($urandom));
         end
      end
   endtask

   task automatic run_random(input int quota);
      int goal;
      goal = work_sent + quota;
      while (work_sent < goal) begin
         if ($urandom_range(0, 99) < 85)
            run_process(goal);
         else
            repeat ($urandom_range(1, 6))
               send_request(2'($urandom_range(0, 3)), ADDR_BITS'($urandom),
                            ADDR_BITS'($urandom));
      end
   endtask

   initial begin
      sb = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_ALLOC;
      req_vaddr       = '0;
      req_span_length = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fault and ignore rules, reserved base, touching segments
      send_request(CMD_ACCESS, 5, 1);
      send_request(CMD_ALLOC, 10, 1);
      send_request(CMD_RSVD, 'hFFFFFF, 'hFFFFFF);
      send_request(CMD_NEW, 0, 0);
      send_request(CMD_RSVD, 0, 0);
      send_request(CMD_ALLOC, 0, 0);
      send_request(CMD_NEW, 'hFFFFFF, 'hFFFFFF);
      send_request(CMD_ALLOC, 200, 50);
      send_request(CMD_ALLOC, 150, 50);
      send_request(CMD_NEW, 0, 0);
      // fill the table exactly to the memory limit, then overflow it
      send_request(CMD_ALLOC, 200, 50);
      send_request(CMD_ACCESS, 200, 50);
      send_request(CMD_ALLOC, 250, 16334);
      send_request(CMD_ALLOC, 'hFFFFFF, 0);
      for (int k = 1; k <= 13; k++)
         send_request(CMD_ALLOC, ADDR_BITS'(k * 'h10000), 0);
      send_request(CMD_ALLOC, 'h800000, 0);
      send_request(CMD_NEW, 0, 0);
      send_request(CMD_ALLOC, 1, 16384);
      send_request(CMD_ALLOC, 'hFFFFFF, 'hFFFFFF);

      write_mem_avail(PHYS_BITS'(16777216));
      run_random(120);
      write_mem_avail('0);
      run_random(30);
      write_mem_avail(PHYS_BITS'($urandom_range(0, 16777216)));
      run_random(100);
      write_mem_avail(PHYS_BITS'(16384));
      run_random(80);
      write_mem_avail(PHYS_BITS'(16777216));
      run_random(100);

      req_valid = 1'b0;
      while (sb.owed_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d allocate grants, %0d access grants, %0d faults (%0d on a full table)",
               sb.alloc_grants, sb.access_grants, sb.faults, sb.full_faults);
      $display("and %0d ignored requests over %0d memory sizes; %0d mismatches.",
               sb.ignored, mem_sizes, sb.errors);
      if (sb.errors == 0 && sb.owed_rsp.size() == 0) begin
         $display("segment_table_allocator_core_test passed");
      end else begin
         $display("segment_table_allocator_core_test failed");
      end
      $finish;
   end

endmodule
